### src/fpf_pkg.sv
// Shared types, codes and tables of the fixed-point to text formatter.
package fpf_pkg;

   localparam int MAX_FIELD_DEF = 32;
   localparam int VALUE_BITS = 32;
   localparam logic [31:0] SIGN_BIT_MASK = 32'h8000_0000;
   localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
   localparam int OCT_LIMIT = 11;
   localparam logic [31:0] NINES9 = 32'd999999999;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_EXP_REQ = 2'd1;
   localparam logic [1:0] ST_EXP_FORCED = 2'd2;
   localparam logic [1:0] ST_BAD_OPT = 2'd3;

   localparam logic [1:0] FN_EXP = 2'd0;
   localparam logic [1:0] FN_HEX = 2'd1;
   localparam logic [1:0] FN_OCT = 2'd2;
   localparam logic [1:0] FN_DEC = 2'd3;

   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_BLANK = 8'h20;
   localparam logic [7:0] CH_POINT = 8'h2E;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_NUL = 8'h00;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_FRAC_A, S_POINT, S_FRAC_B, S_CARRY, S_INT,
      S_HEX, S_OCT, S_SIGN, S_READ, S_SEND, S_REPORT
   } fpf_state_type;

   typedef enum logic [2:0] {
      CHK_ZERO, CHK_INT, CHK_FIXED, CHK_HEX, CHK_OCT, CHK_FAIL
   } fpf_chk_type;

   typedef struct packed {
      fpf_state_type op;
      logic load;
      logic send;
   } fpf_cmd_type;

   typedef struct packed {
      fpf_chk_type chk;
      logic frac_done;
      logic carry_fail;
      logic pd_neg;
      logic int_done;
      logic hex_done;
      logic oct_done;
      logic sign_fail;
      logic last;
   } fpf_stat_type;

   function automatic logic [31:0] pow10(input int i);
      logic [31:0] r;
      r = 32'd1;
      for (int n = 0; n < 9; n++) begin
         if (n < i) r = r * 32'd10;
      end
      return r;
   endfunction

   // largest value with t+1 decimal digits, all ones from ten digits on
   function automatic logic [31:0] fit_limit(input int t);
      logic [31:0] r;
      case (t)
         0: r = 32'd9;
         1: r = 32'd99;
         2: r = 32'd999;
         3: r = 32'd9999;
         4: r = 32'd99999;
         5: r = 32'd999999;
         6: r = 32'd9999999;
         7: r = 32'd99999999;
         8: r = NINES9;
         default: r = (t < 0) ? 32'd0 : 32'hFFFF_FFFF;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] r;
      if (d < 4'd10) r = CH_ZERO + {4'd0, d};
      else r = 8'h41 + {4'd0, d - 4'd10};
      return r;
   endfunction

endpackage

### src/fpf_ctrl.sv
// Sequencing state machine of the formatter.
module fpf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  fpf_pkg::fpf_stat_type st,
   output fpf_pkg::fpf_cmd_type  cmd
);
   import fpf_pkg::*;

   fpf_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_valid) state_in = S_CHECK;
         S_CHECK: begin
            case (st.chk)
               CHK_ZERO:  state_in = S_SIGN;
               CHK_INT:   state_in = S_INT;
               CHK_FIXED: state_in = S_FRAC_A;
               CHK_HEX:   state_in = S_HEX;
               CHK_OCT:   state_in = S_OCT;
               default:   state_in = S_REPORT;
            endcase
         end
         S_FRAC_A: if (st.frac_done) state_in = S_POINT;
         S_POINT: state_in = S_FRAC_B;
         S_FRAC_B: if (st.frac_done) state_in = S_CARRY;
         S_CARRY: state_in = st.carry_fail ? S_REPORT : S_INT;
         S_INT: begin
            if (st.pd_neg) state_in = S_REPORT;
            else if (st.int_done) state_in = S_SIGN;
         end
         S_HEX: if (st.hex_done) state_in = S_SIGN;
         S_OCT: begin
            if (st.pd_neg) state_in = S_REPORT;
            else if (st.oct_done) state_in = S_SIGN;
         end
         S_SIGN: state_in = st.sign_fail ? S_REPORT : S_READ;
         S_READ: state_in = S_SEND;
         S_SEND: begin
            if (!rsp_stall) state_in = st.last ? S_IDLE : S_READ;
         end
         S_REPORT: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_SEND) || (state_ff == S_REPORT);
      cmd.op = state_ff;
      cmd.load = (state_ff == S_IDLE) && req_valid;
      cmd.send = rsp_valid && !rsp_stall;
   end

   a_load_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_CHECK))
      else $error("transfer in did not start the check");
   a_read_send: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (state_ff == S_SEND))
      else $error("buffer read not followed by send");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEND && !rsp_stall && st.last) |=> (state_ff == S_IDLE))
      else $error("last transfer did not end the item");
endmodule

### src/fpf_dp.sv
// Datapath of the formatter: argument registers, digit units and field buffer.
module fpf_dp #(
   parameter int MAX_FIELD = fpf_pkg::MAX_FIELD_DEF
) (
   input  logic                 clock,
   input  fpf_pkg::fpf_cmd_type  cmd,
   output fpf_pkg::fpf_stat_type st,
   input  logic [31:0]          req_value,
   input  logic                 req_signed_input,
   input  logic [1:0]           req_func,
   input  logic [4:0]           req_frac_bits,
   input  logic [3:0]           req_decimals_code,
   input  logic [4:0]           req_width_minus_one,
   input  logic                 req_general_fixed,
   input  logic                 req_left_justify,
   input  logic                 req_underflow_to_exp,
   input  logic                 req_auto_decimal,
   input  logic                 req_zero_pad,
   input  logic [1:0]           req_digit_size,
   output logic [7:0]           rsp_character,
   output logic                 rsp_last,
   output logic [5:0]           rsp_text_length,
   output logic [1:0]           rsp_status
);
   import fpf_pkg::*;

   localparam int AW = $clog2(MAX_FIELD);
   localparam int DW = AW + 1;
   localparam int SW = AW + 3;

   logic [7:0] buf_mem [MAX_FIELD];

   logic [31:0] v_ff, v_in, targ_ff, targ_in, frac_ff, frac_in, frac0_ff, frac0_in;
   logic negv_ff, negv_in, gfp_ff, gfp_in, uf_ff, uf_in, au_ff, au_in;
   logic lj_ff, lj_in, zp_ff, zp_in, nos_ff, nos_in, round_ff, round_in;
   logic hn9_ff, hn9_in;
   logic [1:0] func_ff, func_in, ds_ff, ds_in, stat_ff, stat_in;
   logic [4:0] bs_ff, bs_in;
   logic [AW-1:0] w_ff, w_in;
   logic [DW-1:0] dec_ff, dec_in, j_ff, j_in, ln9_ff, ln9_in, k_ff, k_in;
   logic signed [SW-1:0] pd_ff, pd_in;
   logic [3:0] hcnt_ff, hcnt_in;
   logic [7:0] rd_ff;

   logic we;
   logic [AW-1:0] waddr, raddr;
   logic [7:0] wdata;

   logic signed [SW-1:0] ws, negs, decs, texp, tdec, pde, fwp, tcar, avdig, start, len, ks;
   logic [31:0] targ_c, frac0_c, targ1, q, q10;
   logic [63:0] prod_q;
   logic [35:0] prod_f;
   logic [3:0] l10, fd, fd2, rem, nhex;
   logic [5:0] sa;
   logic [DW-1:0] ndig, dec_new;
   logic zero, fixed, opt_bad, ovf_dec, ovf_hex, ovf_oct, carry, intext;
   fpf_chk_type chk;
   logic [1:0] chk_code;

   always_comb begin
      ws = $signed({{(SW-AW){1'b0}}, w_ff});
      negs = $signed({{(SW-1){1'b0}}, negv_ff});
      decs = $signed({{(SW-DW){1'b0}}, dec_ff});
      targ_c = v_ff >> bs_ff;
      frac0_c = (bs_ff != 5'd0) ? (v_ff << (6'd32 - {1'b0, bs_ff})) : 32'd0;
      zero = (v_ff == 32'd0);
      texp = ws - negs - (au_ff ? SW'(0) : decs);
      ovf_dec = (texp < 0) || (targ_c > fit_limit(int'(texp)));
      fixed = (bs_ff != 5'd0) || (dec_ff != '0) || gfp_ff || au_ff;
      opt_bad = fixed || uf_ff;
      l10 = 4'd0;
      for (int i = 1; i < 10; i++) begin
         if (targ_c >= pow10(i)) l10 = l10 + 4'd1;
      end
      tdec = ws - negs - $signed({{(SW-4){1'b0}}, l10}) - SW'(1);
      if (tdec < 0 || tdec == SW'(1)) tdec = '0;
      dec_new = dec_ff;
      if (au_ff && (dec_ff == '0 || tdec < decs)) dec_new = DW'(tdec);
      nhex = (ds_ff >= 2'd2) ? 4'd2 : ((ds_ff == 2'd1) ? 4'd4 : 4'd8);
      ovf_hex = $signed({{(SW-4){1'b0}}, nhex}) > (ws + SW'(1) - negs);
      avdig = ws - negs;
      sa = avdig[5:0] * 6'd3 + 6'd3;
      ovf_oct = (avdig < 0) || ((avdig < SW'(OCT_LIMIT)) && ((v_ff >> sa) != 32'd0));
      chk_code = ST_OK;
      if (zero) chk = CHK_ZERO;
      else begin
         case (func_ff)
            FN_DEC: begin
               if (ovf_dec) begin chk = CHK_FAIL; chk_code = ST_EXP_FORCED; end
               else chk = fixed ? CHK_FIXED : CHK_INT;
            end
            FN_HEX, FN_OCT: begin
               if (opt_bad) begin chk = CHK_FAIL; chk_code = ST_BAD_OPT; end
               else if ((func_ff == FN_HEX) ? ovf_hex : ovf_oct) begin
                  chk = CHK_FAIL; chk_code = ST_EXP_FORCED;
               end else chk = (func_ff == FN_HEX) ? CHK_HEX : CHK_OCT;
            end
            default: begin chk = CHK_FAIL; chk_code = ST_EXP_REQ; end
         endcase
      end
      ndig = (dec_ff != '0) ? dec_ff - DW'(1) : '0;
      pde = ws + SW'(1) - decs;
      fwp = pde + SW'(1) + $signed({{(SW-DW){1'b0}}, j_ff});
      prod_f = {4'd0, frac_ff} * 36'd10;
      fd = prod_f[35:32];
      if (!round_ff) fd2 = fd;
      else if (hn9_ff && j_ff == ln9_ff) fd2 = fd + 4'd1;
      else if (hn9_ff && j_ff < ln9_ff) fd2 = fd;
      else fd2 = 4'd0;
      carry = round_ff && !hn9_ff;
      tcar = pde - SW'(1) - negs;
      targ1 = targ_ff + 32'd1;
      prod_q = {32'd0, targ_ff} * {32'd0, RECIP10};
      q = 32'(prod_q >> 35);
      q10 = (q << 3) + (q << 1);
      rem = 4'(targ_ff - q10);
      start = pd_ff + SW'(1);
      len = ws - pd_ff;
      ks = $signed({{(SW-DW){1'b0}}, k_ff});
      intext = lj_ff ? (ks < len) : (ks >= start);
      raddr = lj_ff ? AW'(ks + start) : AW'(k_ff);
   end

   always_comb begin
      st.chk = chk;
      st.frac_done = (j_ff == ndig);
      st.carry_fail = (carry && (tcar < 0 || targ1 > fit_limit(int'(tcar))))
         || (uf_ff && nos_ff && !round_ff);
      st.pd_neg = (pd_ff < 0);
      st.int_done = (q == 32'd0);
      st.hex_done = (hcnt_ff == 4'd1);
      st.oct_done = ((v_ff >> 3) == 32'd0);
      st.sign_fail = negv_ff && (pd_ff < 0);
      st.last = (k_ff == DW'(w_ff));
   end

   always_comb begin
      v_in = v_ff; targ_in = targ_ff; frac_in = frac_ff; frac0_in = frac0_ff;
      negv_in = negv_ff; gfp_in = gfp_ff; uf_in = uf_ff; au_in = au_ff;
      lj_in = lj_ff; zp_in = zp_ff; nos_in = nos_ff; round_in = round_ff;
      hn9_in = hn9_ff; func_in = func_ff; ds_in = ds_ff; stat_in = stat_ff;
      bs_in = bs_ff; w_in = w_ff; dec_in = dec_ff; j_in = j_ff; ln9_in = ln9_ff;
      k_in = k_ff; pd_in = pd_ff; hcnt_in = hcnt_ff;
      we = 1'b0; waddr = AW'(pd_ff); wdata = CH_ZERO;
      if (cmd.load) begin
         negv_in = req_signed_input && ((req_value & SIGN_BIT_MASK) != 32'd0);
         v_in = negv_in ? (32'd0 - req_value) : req_value;
         func_in = req_func; bs_in = req_frac_bits; dec_in = DW'(req_decimals_code);
         gfp_in = req_general_fixed; lj_in = req_left_justify;
         uf_in = req_underflow_to_exp; au_in = req_auto_decimal;
         zp_in = req_zero_pad; ds_in = req_digit_size;
         if (int'(req_width_minus_one) > MAX_FIELD - 1) w_in = AW'(MAX_FIELD - 1);
         else w_in = AW'(req_width_minus_one);
      end
      case (cmd.op)
         S_CHECK: begin
            targ_in = targ_c; frac_in = frac0_c; frac0_in = frac0_c;
            dec_in = dec_new; j_in = '0; hn9_in = 1'b0; nos_in = (targ_c == 32'd0);
            hcnt_in = nhex; stat_in = chk_code; pd_in = ws;
            if (zero) begin
               we = 1'b1; waddr = w_ff; wdata = CH_ZERO; pd_in = ws - SW'(1);
            end
         end
         S_FRAC_A: begin
            if (j_ff != ndig) begin
               if (fd != 4'd9) begin ln9_in = j_ff; hn9_in = 1'b1; end
               if (fd != 4'd0) nos_in = 1'b0;
               frac_in = prod_f[31:0];
               j_in = j_ff + DW'(1);
            end
         end
         S_POINT: begin
            round_in = frac_ff[31]; frac_in = frac0_ff; j_in = '0;
            if (dec_ff != '0) begin we = 1'b1; waddr = AW'(pde); wdata = CH_POINT; end
         end
         S_FRAC_B: begin
            if (j_ff != ndig) begin
               we = 1'b1; waddr = AW'(fwp); wdata = digit_char(fd2);
               frac_in = prod_f[31:0];
               j_in = j_ff + DW'(1);
            end
         end
         S_CARRY: begin
            if (carry) targ_in = targ1;
            if (st.carry_fail) stat_in = ST_EXP_FORCED;
            pd_in = ws - decs;
         end
         S_INT: begin
            if (pd_ff < 0) stat_in = ST_EXP_FORCED;
            else begin
               we = 1'b1; wdata = digit_char(rem);
               pd_in = pd_ff - SW'(1); targ_in = q;
            end
         end
         S_HEX: begin
            we = 1'b1; wdata = digit_char(v_ff[3:0]);
            pd_in = pd_ff - SW'(1); v_in = v_ff >> 4; hcnt_in = hcnt_ff - 4'd1;
         end
         S_OCT: begin
            if (pd_ff < 0) stat_in = ST_EXP_FORCED;
            else begin
               we = 1'b1; wdata = digit_char({1'b0, v_ff[2:0]});
               pd_in = pd_ff - SW'(1); v_in = v_ff >> 3;
            end
         end
         S_SIGN: begin
            k_in = '0;
            if (negv_ff) begin
               if (pd_ff < 0) stat_in = ST_EXP_FORCED;
               else begin we = 1'b1; wdata = CH_MINUS; pd_in = pd_ff - SW'(1); end
            end
         end
         S_SEND: if (cmd.send) k_in = k_ff + DW'(1);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in; targ_ff <= targ_in; frac_ff <= frac_in; frac0_ff <= frac0_in;
      negv_ff <= negv_in; gfp_ff <= gfp_in; uf_ff <= uf_in; au_ff <= au_in;
      lj_ff <= lj_in; zp_ff <= zp_in; nos_ff <= nos_in; round_ff <= round_in;
      hn9_ff <= hn9_in; func_ff <= func_in; ds_ff <= ds_in; stat_ff <= stat_in;
      bs_ff <= bs_in; w_ff <= w_in; dec_ff <= dec_in; j_ff <= j_in; ln9_ff <= ln9_in;
      k_ff <= k_in; pd_ff <= pd_in; hcnt_ff <= hcnt_in;
   end

   always_ff @(posedge clock) begin
      if (we) buf_mem[waddr] <= wdata;
      if (cmd.op == S_READ) rd_ff <= buf_mem[raddr];
   end

   always_comb begin
      if (cmd.op == S_REPORT) begin
         rsp_character = CH_NUL; rsp_last = 1'b1;
         rsp_text_length = 6'd0; rsp_status = stat_ff;
      end else begin
         rsp_character = intext ? rd_ff : (zp_ff ? CH_ZERO : CH_BLANK);
         rsp_last = st.last;
         rsp_text_length = 6'(len);
         rsp_status = ST_OK;
      end
   end
endmodule

### src/fixed_point_to_text_formatter.sv
// Top level of the fixed-point to text formatter.
// Sequence: a check state; fixed point adds two fraction passes over the decimals
// plus a point and a carry state; then the integer, hex or octal digits one by one
// and a sign state. Each field character is a buffer read, then a transfer. A new
// request is taken only in idle, after the last transfer of the item; a handoff or
// error status ends after one transfer.
// Synchronous active-high reset returns the controller to idle; buffer is not cleared.
module fixed_point_to_text_formatter #(
   parameter int MAX_FIELD = fpf_pkg::MAX_FIELD_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_value,
   input  logic        req_signed_input,
   input  logic [1:0]  req_func,
   input  logic [4:0]  req_frac_bits,
   input  logic [3:0]  req_decimals_code,
   input  logic [4:0]  req_width_minus_one,
   input  logic        req_general_fixed,
   input  logic        req_left_justify,
   input  logic        req_underflow_to_exp,
   input  logic        req_auto_decimal,
   input  logic        req_zero_pad,
   input  logic [1:0]  req_digit_size,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_character,
   output logic        rsp_last,
   output logic [5:0]  rsp_text_length,
   output logic [1:0]  rsp_status
);
   import fpf_pkg::*;

   fpf_cmd_type cmd;
   fpf_stat_type st;

   fpf_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .st(st), .cmd(cmd)
   );

   fpf_dp #(.MAX_FIELD(MAX_FIELD)) u_dp (
      .clock(clock), .cmd(cmd), .st(st),
      .req_value(req_value), .req_signed_input(req_signed_input),
      .req_func(req_func), .req_frac_bits(req_frac_bits),
      .req_decimals_code(req_decimals_code), .req_width_minus_one(req_width_minus_one),
      .req_general_fixed(req_general_fixed), .req_left_justify(req_left_justify),
      .req_underflow_to_exp(req_underflow_to_exp), .req_auto_decimal(req_auto_decimal),
      .req_zero_pad(req_zero_pad), .req_digit_size(req_digit_size),
      .rsp_character(rsp_character), .rsp_last(rsp_last),
      .rsp_text_length(rsp_text_length), .rsp_status(rsp_status)
   );
endmodule

### tb/sv/fixed_point_to_text_formatter_checker.sv
// Checker for the text formatter: predicts each field and compares every result transfer.
module fixed_point_to_text_formatter_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_value,
   input  logic        req_signed_input,
   input  logic [1:0]  req_func,
   input  logic [4:0]  req_frac_bits,
   input  logic [3:0]  req_decimals_code,
   input  logic [4:0]  req_width_minus_one,
   input  logic        req_general_fixed,
   input  logic        req_left_justify,
   input  logic        req_underflow_to_exp,
   input  logic        req_auto_decimal,
   input  logic        req_zero_pad,
   input  logic [1:0]  req_digit_size,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_character,
   input  logic        rsp_last,
   input  logic [5:0]  rsp_text_length,
   input  logic [1:0]  rsp_status,
   output int          mismatch_count,
   output int          chars_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import fpf_pkg::*;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
      logic [5:0] text_length;
      logic [1:0] status;
   } field_char_type;

   field_char_type expected_chars[$];

   function automatic logic [7:0] to_digit(input logic [3:0] d);
      return (d < 4'd10) ? (8'h30 + {4'd0, d}) : (8'h41 + {4'd0, d} - 8'd10);
   endfunction

   function automatic logic [31:0] pow10_of(input int t);
      logic [31:0] r;
      r = 32'd1;
      for (int n = 0; n < t; n++) r = r * 32'd10;
      return r;
   endfunction

   // largest value with t+1 decimal digits, all ones from ten digits on
   function automatic logic [31:0] nines(input int t);
      if (t < 0) return 32'd0;
      if (t >= 9) return 32'hFFFF_FFFF;
      return pow10_of(t + 1) - 32'd1;
   endfunction

   // builds the digits right-aligned at position w; left gets leftmost written minus one
   function automatic logic [1:0] build_text(
         input logic [31:0] v_in, input logic negv, input int w, input logic [1:0] fn,
         input int bs, input int dec_in, input logic gfp, input logic uf, input logic au,
         input logic [1:0] ds, inout logic [7:0] fb [32], output int left);
      logic [31:0] v, targ, frac, q;
      logic [63:0] prod;
      logic nos, done;
      int pd, dec, texp, pde, p, l10, tdec, t, nhex, avdig, sgn;
      v = v_in;
      dec = dec_in;
      pd = w;
      sgn = negv;
      left = 0;
      if (v == 0) begin
         fb[pd] = "0";
         pd--;
      end else if (fn == FN_DEC) begin
         targ = v >> bs;
         texp = w - sgn - (au ? 0 : dec);
         if (texp < 0 || targ > nines(texp)) return ST_EXP_FORCED;
         if (bs != 0 || dec != 0 || gfp || au) begin
            frac = (bs != 0) ? (v << (32 - bs)) : 32'd0;
            nos = (targ == 0);
            if (au) begin
               l10 = 0;
               q = targ;
               while (q >= 10) begin
                  q = q / 10;
                  l10++;
               end
               tdec = w - sgn - l10 - 1;
               if (tdec < 0 || tdec == 1) tdec = 0;
               if (dec == 0 || tdec < dec) dec = tdec;
            end
            pde = w + 1 - dec;
            p = pde;
            if (dec > 0) begin
               fb[p] = ".";
               p++;
               while (p <= w) begin
                  prod = {32'd0, frac} * 64'd10;
                  if (prod[35:32] != 0) nos = 0;
                  fb[p] = to_digit(prod[35:32]);
                  p++;
                  frac = prod[31:0];
               end
            end
            if (frac[31]) begin
               done = 0;
               nos = 0;
               p--;
               while (p > pde && !done) begin
                  if (fb[p] < "9") begin
                     fb[p] = fb[p] + 8'd1;
                     done = 1;
                  end else begin
                     fb[p] = "0";
                     p--;
                  end
               end
               if (!done) begin
                  t = pde - 1 - sgn;
                  targ = targ + 1;
                  if (t < 0 || targ > nines(t)) return ST_EXP_FORCED;
               end
            end
            if (uf && nos) return ST_EXP_FORCED;
            pd = w - dec;
         end
         do begin
            q = targ / 10;
            if (pd < 0) return ST_EXP_FORCED;
            fb[pd] = to_digit(4'(targ - q * 10));
            pd--;
            targ = q;
         end while (targ != 0);
      end else if (fn == FN_HEX || fn == FN_OCT) begin
         if (bs != 0 || dec != 0 || gfp || uf || au) return ST_BAD_OPT;
         if (fn == FN_HEX) begin
            nhex = (ds >= 2) ? 2 : ((ds == 1) ? 4 : 8);
            if (nhex > w + 1 - sgn) return ST_EXP_FORCED;
            while (nhex > 0) begin
               fb[pd] = to_digit(v[3:0]);
               pd--;
               v = v >> 4;
               nhex--;
            end
         end else begin
            avdig = w - sgn;
            if (avdig < 0 || (avdig < 11 && {32'd0, v} >= (64'd8 << (3 * avdig))))
               return ST_EXP_FORCED;
            do begin
               if (pd < 0) return ST_EXP_FORCED;
               fb[pd] = to_digit({1'b0, v[2:0]});
               pd--;
               v = v >> 3;
            end while (v != 0);
         end
      end else begin
         return ST_EXP_REQ;
      end
      if (negv) begin
         if (pd < 0) return ST_EXP_FORCED;
         fb[pd] = "-";
         pd--;
      end
      left = pd;
      return ST_OK;
   endfunction

   function automatic void predict_field();
      logic [7:0] fb [32];
      logic [31:0] v;
      logic negv;
      logic [1:0] st;
      logic [7:0] fill;
      int w, left, start, len;
      field_char_type c;
      for (int k = 0; k < 32; k++) fb[k] = 8'd0;
      v = req_value;
      negv = 0;
      w = req_width_minus_one;
      fill = req_zero_pad ? "0" : " ";
      if (req_signed_input && v[31]) begin
         v = 32'd0 - v;
         negv = 1;
      end
      st = build_text(v, negv, w, req_func, req_frac_bits, req_decimals_code,
                      req_general_fixed, req_underflow_to_exp, req_auto_decimal,
                      req_digit_size, fb, left);
      if (st != ST_OK) begin
         c = '{character: 8'd0, last: 1'b1, text_length: 6'd0, status: st};
         expected_chars.push_back(c);
         return;
      end
      start = left + 1;
      len = w - start + 1;
      if (req_left_justify) begin
         for (int k = 0; k < len; k++) fb[k] = fb[start + k];
         for (int k = len; k <= w; k++) fb[k] = fill;
      end else begin
         for (int k = 0; k < start; k++) fb[k] = fill;
      end
      for (int k = 0; k <= w; k++) begin
         c = '{character: fb[k], last: (k == w), text_length: 6'(len), status: ST_OK};
         expected_chars.push_back(c);
      end
   endfunction

   initial mismatch_count = 0;
   assign chars_pending = expected_chars.size();

   always @(posedge clock) begin
      field_char_type e;
      if (!reset) begin
         if (req_valid && !req_stall) predict_field();
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected transfer char=%h last=%b len=%0d status=%0d",
                        $time, rsp_character, rsp_last, rsp_text_length, rsp_status);
               mismatch_count++;
            end else begin
               e = expected_chars.pop_front();
               if (rsp_character !== e.character) begin
                  $display("%0t: character expected %h actual %h", $time, e.character,
                           rsp_character);
                  mismatch_count++;
               end
               if (rsp_last !== e.last) begin
                  $display("%0t: last expected %b actual %b", $time, e.last, rsp_last);
                  mismatch_count++;
               end
               if (rsp_text_length !== e.text_length) begin
                  $display("%0t: text_length expected %0d actual %0d", $time,
                           e.text_length, rsp_text_length);
                  mismatch_count++;
               end
               if (rsp_status !== e.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, e.status,
                           rsp_status);
                  mismatch_count++;
               end
            end
         end
      end
   end

endmodule

### tb/sv/fixed_point_to_text_formatter_tb.sv
// Top of the text formatter testbench: clock, reset, stimulus and verdict.
module fixed_point_to_text_formatter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fpf_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [31:0] req_value = 0;
   logic        req_signed_input = 0;
   logic [1:0]  req_func = 0;
   logic [4:0]  req_frac_bits = 0;
   logic [3:0]  req_decimals_code = 0;
   logic [4:0]  req_width_minus_one = 0;
   logic        req_general_fixed = 0;
   logic        req_left_justify = 0;
   logic        req_underflow_to_exp = 0;
   logic        req_auto_decimal = 0;
   logic        req_zero_pad = 0;
   logic [1:0]  req_digit_size = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [7:0]  rsp_character;
   logic        rsp_last;
   logic [5:0]  rsp_text_length;
   logic [1:0]  rsp_status;
   int          mismatch_count;
   int          chars_pending;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   fixed_point_to_text_formatter dut (.*);
   fixed_point_to_text_formatter_checker checker_i (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   task automatic send_item(input logic [31:0] v, input logic sg, input logic [1:0] fn,
                            input logic [4:0] fb, input logic [3:0] dc, input logic [4:0] w,
                            input logic gf, input logic lj, input logic uf, input logic au,
                            input logic zp, input logic [1:0] ds);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_valid <= 1;
      req_value <= v;
      req_signed_input <= sg;
      req_func <= fn;
      req_frac_bits <= fb;
      req_decimals_code <= dc;
      req_width_minus_one <= w;
      req_general_fixed <= gf;
      req_left_justify <= lj;
      req_underflow_to_exp <= uf;
      req_auto_decimal <= au;
      req_zero_pad <= zp;
      req_digit_size <= ds;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_random();
      logic [31:0] v;
      logic [1:0] fn;
      logic clean;
      v = $urandom() >> $urandom_range(31);
      if ($urandom_range(9) == 0) v = 32'd0;
      fn = ($urandom_range(9) < 6) ? FN_DEC : 2'($urandom_range(3));
      clean = ($urandom_range(9) < 8);
      if (fn == FN_HEX || fn == FN_OCT) begin
         if (clean)
            send_item(v, $urandom_range(1), fn, 0, 0, $urandom_range(31), 0,
                      $urandom_range(1), 0, 0, $urandom_range(1), $urandom_range(3));
         else
            send_item(v, $urandom_range(1), fn, $urandom_range(31), $urandom_range(15),
                      $urandom_range(31), $urandom_range(1), $urandom_range(1),
                      $urandom_range(1), $urandom_range(1), $urandom_range(1),
                      $urandom_range(3));
      end else begin
         send_item(v, $urandom_range(1), fn, $urandom_range(31), $urandom_range(15),
                   clean ? $urandom_range(31, 8) : $urandom_range(31), $urandom_range(1),
                   $urandom_range(1), $urandom_range(3) == 0, $urandom_range(1),
                   $urandom_range(1), $urandom_range(3));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      // directed: zero, handoff, extremes, hex sizes, octal, bad options, rounding, underflow, auto decimals
      send_item(32'd0, 0, FN_EXP, 0, 0, 7, 0, 0, 0, 0, 0, 0);
      send_item(32'd5, 0, FN_EXP, 0, 0, 7, 0, 0, 0, 0, 0, 0);
      send_item(32'h8000_0000, 1, FN_DEC, 0, 0, 15, 0, 0, 0, 0, 0, 0);
      send_item(32'hFFFF_FFFF, 0, FN_DEC, 0, 0, 31, 0, 1, 0, 0, 1, 0);
      send_item(32'hFFFF_FFFF, 1, FN_DEC, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_item(32'hDEAD_BEEF, 0, FN_HEX, 0, 0, 9, 0, 0, 0, 0, 0, 0);
      send_item(32'hDEAD_BEEF, 0, FN_HEX, 0, 0, 9, 0, 0, 0, 0, 1, 1);
      send_item(32'hDEAD_BEEF, 1, FN_HEX, 0, 0, 9, 0, 1, 0, 0, 0, 2);
      send_item(32'hDEAD_BEEF, 0, FN_HEX, 0, 0, 1, 0, 0, 0, 0, 0, 3);
      send_item(32'hDEAD_BEEF, 0, FN_HEX, 0, 0, 3, 0, 0, 0, 0, 0, 0);
      send_item(32'o1234567, 0, FN_OCT, 0, 0, 12, 0, 0, 0, 0, 0, 0);
      send_item(32'hFFFF_FFFF, 0, FN_OCT, 0, 0, 10, 0, 0, 0, 0, 0, 0);
      send_item(32'h0000_0012, 0, FN_HEX, 3, 0, 9, 0, 0, 0, 0, 0, 0);
      send_item(32'h0000_0012, 0, FN_OCT, 0, 0, 9, 0, 0, 1, 0, 0, 0);
      send_item(32'h0000_0FFF, 0, FN_DEC, 12, 3, 9, 0, 0, 0, 0, 0, 0);
      send_item(32'h0000_0FFF, 0, FN_DEC, 12, 3, 2, 0, 0, 0, 0, 0, 0);
      send_item(32'h0000_0001, 0, FN_DEC, 31, 3, 9, 0, 0, 1, 0, 0, 0);
      send_item(32'h0001_8000, 1, FN_DEC, 16, 0, 11, 0, 0, 0, 1, 1, 0);
      send_item(32'd12345, 0, FN_DEC, 0, 0, 4, 0, 0, 0, 1, 0, 0);
      send_item(-32'sd42, 1, FN_DEC, 0, 0, 9, 0, 0, 0, 0, 1, 0);
      send_item(-32'sd42, 1, FN_DEC, 0, 0, 9, 0, 1, 0, 0, 1, 0);
      send_item(32'd123456, 0, FN_DEC, 0, 0, 3, 0, 0, 0, 0, 0, 0);
      send_item(32'd7, 0, FN_DEC, 0, 0, 5, 1, 0, 0, 0, 0, 0);
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 66 : 23) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 66 : 23) : 0;
         for (int n = 0; n < 32; n++) send_random();
      end
      req_valid <= 0;
      // let the checker log the final transfer before polling the queue
      @(posedge clock);
      while (chars_pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && chars_pending == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
